### src/circular_list_append_remove_unit_assert.svh
// Assertion macros for the circular list append and remove unit.
`ifndef CIRCULAR_LIST_APPEND_REMOVE_UNIT_ASSERT_SVH
`define CIRCULAR_LIST_APPEND_REMOVE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CLAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CLAR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define CLAR_ASSERT(lbl, prop, msg)
`define CLAR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### src/clar_pkg.sv
// Types and codes shared by the circular list append and remove unit.
`timescale 1ns / 1ps
`default_nettype none
package clar_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_NEW,
    ST_APP_TAIL,
    ST_WALK,
    ST_UNLINK,
    ST_FREE,
    ST_DONE
  } clar_state_e;

endpackage
`default_nettype wire

### src/clar_if.sv
// Valid and ready channel interfaces for the list request and result items.
`timescale 1ns / 1ps
`default_nettype none
interface clar_in_if;
  import clar_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface clar_out_if;
  import clar_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink (input valid, input status, input entry_count, output ready);
endinterface
`default_nettype wire

### src/clar_node_mem.sv
// Node value and link memories with one shared registered read port.
`timescale 1ns / 1ps
`default_nettype none
module clar_node_mem #(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned VAL_W      = 32,
  localparam int unsigned IW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic [IW-1:0]    raddr_i,
  input  wire logic             val_we_i,
  input  wire logic [IW-1:0]    val_waddr_i,
  input  wire logic [VAL_W-1:0] val_wdata_i,
  input  wire logic             link_we_i,
  input  wire logic [IW-1:0]    link_waddr_i,
  input  wire logic [IW-1:0]    link_wdata_i,
  output logic      [VAL_W-1:0] val_rdata_o,
  output logic      [IW-1:0]    link_rdata_o
);

  logic [VAL_W-1:0] val_mem  [LIST_DEPTH];
  logic [IW-1:0]    link_mem [LIST_DEPTH];
  logic [VAL_W-1:0] val_rdata_q;
  logic [IW-1:0]    link_rdata_q;

  always_ff @(posedge clk_i) begin
    if (val_we_i) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    val_rdata_q  <= val_mem[raddr_i];
    link_rdata_q <= link_mem[raddr_i];
  end

  assign val_rdata_o  = val_rdata_q;
  assign link_rdata_o = link_rdata_q;

endmodule
`default_nettype wire

### src/circular_list_append_remove_unit.sv
// Steps: an append writes the new node and then links it behind the tail, with no tail link
// into an empty list, and skips straight to its answer when the list is full; a remove walks
// from the head to the first match, then unlinks and frees that node, walks the whole list when
// none matches and skips straight to its answer on an empty list. Throughput: one item at a time;
// the walk follows one link per cycle through the shared read port of the node memories.
// Reset: asynchronous and active low; the list is empty and the node memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_list_append_remove_unit_assert.svh"
module circular_list_append_remove_unit
  import clar_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  clar_in_if.sink   in_i,
  clar_out_if.source out_o
);

  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  clar_state_e state_q, state_d;

  logic [IW-1:0]       head_q, head_d;
  logic [IW-1:0]       tail_q, tail_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [IW-1:0]       free_top_q, free_top_d;
  logic [IW-1:0]       cur_q, cur_d;
  logic [IW-1:0]       prev_q, prev_d;
  logic [IW-1:0]       new_q, new_d;
  logic [IW-1:0]       nxt_q, nxt_d;
  logic [CW-1:0]       steps_q, steps_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [STATUS_W-1:0] res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  logic [IW-1:0]      raddr;
  logic               val_we;
  logic [IW-1:0]      val_waddr;
  logic               link_we;
  logic [IW-1:0]      link_waddr;
  logic [IW-1:0]      link_wdata;
  logic [VALUE_W-1:0] val_rdata;
  logic [IW-1:0]      link_rdata;

  logic          in_fire;
  logic          from_free;
  logic [IW-1:0] alloc_slot;
  logic          match;
  logic          walk_end;
  logic          out_free;
  logic [31:0]   count_ext;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign from_free   = (fill_q != count_q);
  assign alloc_slot  = from_free ? free_top_q : fill_q[IW-1:0];
  assign match       = (val_rdata == value_q);
  assign walk_end    = ((steps_q + CW'(1)) == count_q);
  assign out_free    = !out_valid_q || out_o.ready;
  assign count_ext   = 32'(count_q);

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;

  clar_node_mem #(
    .LIST_DEPTH(LIST_DEPTH),
    .VAL_W     (VALUE_W)
  ) u_node_mem (
    .clk_i       (clk_i),
    .raddr_i     (raddr),
    .val_we_i    (val_we),
    .val_waddr_i (val_waddr),
    .val_wdata_i (value_q),
    .link_we_i   (link_we),
    .link_waddr_i(link_waddr),
    .link_wdata_i(link_wdata),
    .val_rdata_o (val_rdata),
    .link_rdata_o(link_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.func == FUNC_APPEND) begin
            state_d = (count_q == CW'(LIST_DEPTH)) ? ST_DONE : ST_APP_NEW;
          end else begin
            state_d = (count_q == '0) ? ST_DONE : ST_WALK;
          end
        end
      end
      ST_APP_NEW: begin
        state_d = (count_q == '0) ? ST_DONE : ST_APP_TAIL;
      end
      ST_APP_TAIL: begin
        state_d = ST_DONE;
      end
      ST_WALK: begin
        if (match) begin
          state_d = ST_UNLINK;
        end else if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_UNLINK: begin
        state_d = ST_FREE;
      end
      ST_FREE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    fill_d       = fill_q;
    free_top_d   = free_top_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    new_d        = new_q;
    nxt_d        = nxt_q;
    steps_d      = steps_q;
    value_d      = value_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    raddr        = cur_q;
    val_we       = 1'b0;
    val_waddr    = alloc_slot;
    link_we      = 1'b0;
    link_waddr   = cur_q;
    link_wdata   = free_top_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        raddr = (in_i.func == FUNC_REMOVE) ? head_q : free_top_q;
        if (in_fire) begin
          value_d = in_i.value;
          cur_d   = head_q;
          steps_d = '0;
          if (in_i.func == FUNC_APPEND) begin
            res_d = STATUS_FULL;
          end else begin
            res_d = STATUS_NOT_FOUND;
          end
        end
      end
      ST_APP_NEW: begin
        val_we     = 1'b1;
        val_waddr  = alloc_slot;
        link_we    = 1'b1;
        link_waddr = alloc_slot;
        link_wdata = (count_q == '0) ? alloc_slot : head_q;
        new_d      = alloc_slot;
        res_d      = STATUS_INSERTED;
        if (from_free) begin
          free_top_d = link_rdata;
        end else begin
          fill_d = fill_q + CW'(1);
        end
        if (count_q == '0) begin
          head_d  = alloc_slot;
          tail_d  = alloc_slot;
          count_d = count_q + CW'(1);
        end
      end
      ST_APP_TAIL: begin
        link_we    = 1'b1;
        link_waddr = tail_q;
        link_wdata = new_q;
        tail_d     = new_q;
        count_d    = count_q + CW'(1);
      end
      ST_WALK: begin
        if (match) begin
          nxt_d = link_rdata;
          res_d = STATUS_REMOVED;
        end else begin
          raddr   = link_rdata;
          prev_d  = cur_q;
          cur_d   = link_rdata;
          steps_d = steps_q + CW'(1);
        end
      end
      ST_UNLINK: begin
        if (steps_q == '0) begin
          if (count_q == CW'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            link_we    = 1'b1;
            link_waddr = tail_q;
            link_wdata = nxt_q;
            head_d     = nxt_q;
          end
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q;
          link_wdata = nxt_q;
          if (cur_q == tail_q) begin
            tail_d = prev_q;
          end
        end
      end
      ST_FREE: begin
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = free_top_q;
        free_top_d = cur_q;
        count_d    = count_q - CW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_count_d  = count_ext[COUNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      free_top_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      free_top_q  <= free_top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    new_q        <= new_d;
    nxt_q        <= nxt_d;
    steps_q      <= steps_d;
    value_q      <= value_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  `CLAR_ASSERT(a_fill_bounds, (count_q <= fill_q && fill_q <= CW'(LIST_DEPTH)), "fill count out of range")
  `CLAR_ASSERT_IMPL(a_walk_bound, state_q == ST_WALK, steps_q < count_q, "walk past list end")
  `CLAR_ASSERT(a_free_dec, (state_q == ST_FREE) |=> (count_q == $past(count_q) - CW'(1)), "count not decremented")

endmodule
`default_nettype wire
